FILE: src/mtg_pkg.sv
// Package for the MT19937 generator: item codes, table geometry, recurrence
// constants, the sequencer state type and the word-level twist and tempering
// functions. Depends on nothing.
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int IDX_W         = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  // Item codes on in_op.
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam idx_t IDX_END      = IDX_W'(STATE_WORDS);
  localparam idx_t IDX_LAST     = IDX_W'(STATE_WORDS - 1);
  localparam idx_t IDX_NEVER    = IDX_W'(STATE_WORDS + 1);
  localparam idx_t IDX_MID_OFS  = IDX_W'(MIDDLE_OFFSET);

  localparam word_t TWIST_MATRIX  = 32'h9908_b0df;
  localparam word_t HIGH_BIT_MASK = 32'h8000_0000;
  localparam word_t LOW_BITS_MASK = 32'h7fff_ffff;
  localparam word_t SEED_MULT     = 32'd1812433253;
  localparam word_t TEMPER_B      = 32'h9d2c_5680;
  localparam word_t TEMPER_C      = 32'hefc6_0000;
  localparam word_t DEFAULT_SEED  = 32'd5489;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_DRAW_PRE,
    ST_DRAW_LOAD,
    ST_DRAW_WR
  } mtg_state_t;

  // One step of the twist recurrence for a single table word.
  function automatic word_t twist_word(input word_t cur, input word_t nxt,
                                       input word_t mid);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT_MASK) | (nxt & LOW_BITS_MASK);
    v = mid ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Output tempering: four shift-and-xor steps.
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: src/mersenne_twister_generator.sv
// Top level of the MT19937 generator: state table memory, seeding and
// twist sequencer, tempering and the result register.
// Depends on mtg_pkg.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_op (1), in_seed (32)
//  out      output     out_valid / out_stall out_random_word (32)
//
// A draw goes straight to ST_DRAW_WR when the word of the current index is already
// held in the look-ahead register, and runs ST_DRAW_PRE, ST_DRAW_LOAD and ST_DRAW_WR
// otherwise (first draw after a seed), as the table has registered read ports.
// A seed runs the accept cycle, one write of the seed, then a multiply state and an
// add state per remaining word for the 32x32 multiply and the add. A draw before
// any seed first runs that seeding with the default seed.
// Reset clears the sequencer and marks the table as never seeded; the table
// itself is not cleared. A stalled result holds in the output register while
// the next word is accepted; a draw only waits for a free output register.
module mersenne_twister_generator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_op,
  input  mtg_pkg::word_t in_seed,
  output logic          out_valid,
  input  logic          out_stall,
  output mtg_pkg::word_t out_random_word
);
  import mtg_pkg::*;

  // The table: two registered read ports, one write port.
  word_t mem [STATE_WORDS];
  word_t rda_r;
  word_t rdb_r;
  logic  mem_we;
  idx_t  mem_wa;
  word_t mem_wd;
  logic  mem_re;
  idx_t  mem_ra_a;
  idx_t  mem_ra_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rda_r <= mem[mem_ra_a];
      rdb_r <= mem[mem_ra_b];
    end
  end

  mtg_state_t state_r, state_nxt;
  idx_t  idx_r, idx_nxt;       // read index, IDX_NEVER until the first seed
  idx_t  cnt_r, cnt_nxt;       // seeding position
  word_t prev_r, prev_nxt;     // last seeded word
  word_t prod_r, prod_nxt;     // product of the seeding multiply
  word_t cur_r, cur_nxt;       // current table word at the read position
  logic  cache_r, cache_nxt;   // cur_r holds the word at the read position
  logic  pend_r, pend_nxt;     // a draw waits for the default seeding
  logic  out_valid_r, out_valid_nxt;
  word_t out_word_r, out_word_nxt;

  logic  in_acc;
  logic  out_free;
  idx_t  k;
  idx_t  k_nxt;
  idx_t  k_mid;
  idx_t  mid_sum;
  word_t tw;
  word_t seed_sum;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign out_free        = !(out_valid_r && out_stall);

  // Word positions of the draw. The twist is done lazily, one word per draw:
  // words below the read position already belong to the new generation, so
  // the middle word and the wrap-around word read exactly what a whole-table
  // twist would have used.
  assign k       = (idx_r >= IDX_END) ? '0 : idx_r;
  assign k_nxt   = (k == IDX_LAST) ? '0 : k + idx_t'(1);
  assign mid_sum = k + IDX_MID_OFS;
  assign k_mid   = (mid_sum >= IDX_END) ? mid_sum - IDX_END : mid_sum;
  assign tw      = twist_word(cur_r, rda_r, rdb_r);
  assign seed_sum = prod_r + {{(32-IDX_W){1'b0}}, cnt_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SEED || idx_r == IDX_NEVER) begin
            state_nxt = ST_SEED_INIT;
          end else if (cache_r) begin
            state_nxt = ST_DRAW_WR;
          end else begin
            state_nxt = ST_DRAW_PRE;
          end
        end
      end
      ST_SEED_INIT: state_nxt = ST_SEED_MUL;
      ST_SEED_MUL:  state_nxt = ST_SEED_ADD;
      ST_SEED_ADD: begin
        if (cnt_r == IDX_LAST) begin
          state_nxt = pend_r ? ST_DRAW_PRE : ST_IDLE;
        end else begin
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_DRAW_PRE:  state_nxt = ST_DRAW_LOAD;
      ST_DRAW_LOAD: state_nxt = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls and datapath.
  always_comb begin
    mem_we        = 1'b0;
    mem_wa        = k;
    mem_wd        = tw;
    mem_re        = 1'b0;
    mem_ra_a      = k_nxt;
    mem_ra_b      = k_mid;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    cache_nxt     = cache_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        // Reads for a cached draw go out ahead of the accept.
        mem_re = 1'b1;
        if (in_acc) begin
          if (in_op == OP_SEED) begin
            prev_nxt  = in_seed;
            cache_nxt = 1'b0;
            pend_nxt  = 1'b0;
          end else if (idx_r == IDX_NEVER) begin
            prev_nxt  = DEFAULT_SEED;
            cache_nxt = 1'b0;
            pend_nxt  = 1'b1;
          end
        end
      end
      ST_SEED_INIT: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = prev_r;
        cnt_nxt = idx_t'(1);
      end
      ST_SEED_MUL: begin
        prod_nxt = SEED_MULT * (prev_r ^ (prev_r >> 30));
      end
      ST_SEED_ADD: begin
        mem_we   = 1'b1;
        mem_wa   = cnt_r;
        mem_wd   = seed_sum;
        prev_nxt = seed_sum;
        cnt_nxt  = cnt_r + idx_t'(1);
        if (cnt_r == IDX_LAST) begin
          idx_nxt = IDX_END;
        end
      end
      ST_DRAW_PRE: begin
        mem_re   = 1'b1;
        mem_ra_a = k;
        pend_nxt = 1'b0;
      end
      ST_DRAW_LOAD: begin
        cur_nxt = rda_r;
        mem_re  = 1'b1;
      end
      ST_DRAW_WR: begin
        if (out_free) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = temper(tw);
          // The word after this one has not been twisted yet and stays
          // untouched until the next draw, so it is kept for that draw.
          cur_nxt       = rda_r;
          cache_nxt     = 1'b1;
          idx_nxt       = k + idx_t'(1);
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_NEVER;
      cache_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cache_r     <= cache_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

FILE: src/mtg_checker.sv
// Port-level checks for the MT19937 generator and the bind that attaches
// them to mersenne_twister_generator. Depends on mtg_pkg for the word type.
module mtg_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           in_op,
  input mtg_pkg::word_t in_seed,
  input logic           out_valid,
  input logic           out_stall,
  input mtg_pkg::word_t out_random_word
);
  import mtg_pkg::*;

  // A stalled word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_word))
    else $error("stalled output word changed");

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_op) && $stable(in_seed))
    else $error("stalled input word changed");

  // Every accepted word makes the block busy, so the input stalls after the accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted without a busy cycle");

  // A seed word never produces a result right away.
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_SEED) && !out_valid |=> !out_valid)
    else $error("seed word produced a result");

  // A new result appears only at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_op           (in_op),
  .in_seed         (in_seed),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_random_word (out_random_word)
);
